### sv/mmri_pkg.sv
`timescale 1ns / 1ps

package mmri_pkg;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] len;
    logic [7:0]  kind;
  } region_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CARRY_IN,
    OP_CARRY_REST,
    OP_SWAP,
    OP_WR_CARRY,
    OP_WR_RD,
    OP_LOAD_L,
    OP_LOAD_R,
    OP_ENDS,
    OP_DECIDE,
    OP_WR_L,
    OP_WR_R,
    OP_EMIT_RD,
    OP_EMIT_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_en;
  } dp_cmd_t;

  typedef struct packed {
    logic       wr_l;
    logic       wr_r;
    logic       drop_lo;
    logic       drop_hi;
    logic       add_rest;
    logic [1:0] adv;
  } verdict_t;

  typedef struct packed {
    logic     lt;
    verdict_t verdict;
  } dp_sts_t;

  function automatic logic [63:0] sat_sub(logic [64:0] a, logic [64:0] b);
    logic [64:0] d;
    d = a - b;
    return d[64] ? {64{1'b1}} : d[63:0];
  endfunction

endpackage

### sv/mmri_datapath.sv
`timescale 1ns / 1ps

module mmri_datapath #(
  parameter int AW = 5
) (
  input  logic                  clk,
  input  mmri_pkg::dp_cmd_t     cmd,
  input  logic [AW-1:0]         rd_addr,
  input  logic [AW-1:0]         wr_addr,
  input  logic [63:0]           in_start,
  input  logic [63:0]           in_length,
  input  logic [7:0]            in_kind,
  output mmri_pkg::dp_sts_t     sts,
  output logic [63:0]           out_start,
  output logic [63:0]           out_length,
  output logic [7:0]            out_kind
);

  mmri_pkg::region_t mem [2**AW];
  mmri_pkg::region_t rd_q_r;
  mmri_pkg::region_t carry_r;
  mmri_pkg::region_t l_r;
  mmri_pkg::region_t r_r;
  mmri_pkg::region_t rest_r;
  logic [64:0]       el_r;
  logic [64:0]       er_r;
  logic [63:0]       ostart_r;
  logic [63:0]       olen_r;
  logic [7:0]        okind_r;

  logic              wr_en;
  mmri_pkg::region_t wr_data;

  always_comb begin
    wr_en   = 1'b1;
    wr_data = carry_r;
    case (cmd.op)
      mmri_pkg::OP_SWAP:     wr_data = carry_r;
      mmri_pkg::OP_WR_CARRY: wr_data = carry_r;
      mmri_pkg::OP_WR_RD:    wr_data = rd_q_r;
      mmri_pkg::OP_WR_L:     wr_data = l_r;
      mmri_pkg::OP_WR_R:     wr_data = r_r;
      default:               wr_en   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // pair evaluation
  logic [63:0] ls, rs;
  logic        ov, same, l_low, cont_rl, cont_lr, have_rest, touch;
  logic [64:0] m;
  logic [63:0] merge_len, trim_len, rest_len, rnew_len, touch_len;
  mmri_pkg::verdict_t v;

  always_comb begin
    ls        = l_r.start;
    rs        = r_r.start;
    ov        = (rs < ls) ? (er_r > {1'b0, ls}) : ({1'b0, rs} < el_r);
    same      = l_r.kind == r_r.kind;
    l_low     = l_r.kind < r_r.kind;
    m         = (er_r > el_r) ? er_r : el_r;
    merge_len = mmri_pkg::sat_sub(m, {1'b0, ls});
    cont_rl   = (ls >= rs) && (el_r <= er_r);
    cont_lr   = (rs >= ls) && (er_r <= el_r);
    trim_len  = (rs > ls) ? (rs - ls) : 64'd0;
    have_rest = !er_r[64];
    rest_len  = mmri_pkg::sat_sub(el_r, er_r);
    rnew_len  = mmri_pkg::sat_sub(er_r, el_r);
    touch     = !el_r[64] && (el_r[63:0] == rs) && same;
    touch_len = mmri_pkg::sat_sub(er_r, {1'b0, ls});
    v         = '0;
    v.adv     = 2'd1;
    if (ov) begin
      if (same) begin
        v.wr_l    = 1'b1;
        v.drop_hi = 1'b1;
        v.adv     = 2'd0;
      end else if (l_low) begin
        if (cont_rl) begin
          v.drop_lo = 1'b1;
          v.adv     = 2'd0;
        end else if (el_r <= er_r) begin
          v.wr_l = 1'b1;
        end else begin
          v.wr_l    = 1'b1;
          v.drop_lo = trim_len == 64'd0;
          if (!have_rest) begin
            v.adv = v.drop_lo ? 2'd0 : 2'd1;
          end else begin
            v.add_rest = 1'b1;
            v.adv      = 2'd2;
          end
        end
      end else if (cont_lr || (er_r <= el_r) || el_r[64]) begin
        v.drop_hi = 1'b1;
        v.adv     = 2'd0;
      end else begin
        v.wr_r = 1'b1;
      end
    end else if (touch) begin
      v.wr_l    = 1'b1;
      v.drop_hi = 1'b1;
      v.adv     = 2'd0;
    end
  end

  assign sts.verdict = v;
  assign sts.lt = (carry_r.start < rd_q_r.start) ||
                  ((carry_r.start == rd_q_r.start) && (carry_r.len < rd_q_r.len));

  always_ff @(posedge clk) begin
    case (cmd.op)
      mmri_pkg::OP_CARRY_IN: begin
        carry_r.start <= in_start;
        carry_r.len   <= in_length;
        carry_r.kind  <= in_kind;
      end
      mmri_pkg::OP_CARRY_REST: carry_r <= rest_r;
      mmri_pkg::OP_SWAP:       carry_r <= rd_q_r;
      mmri_pkg::OP_LOAD_L:     l_r <= rd_q_r;
      mmri_pkg::OP_LOAD_R:     r_r <= rd_q_r;
      mmri_pkg::OP_ENDS: begin
        el_r <= {1'b0, l_r.start} + {1'b0, l_r.len};
        er_r <= {1'b0, r_r.start} + {1'b0, r_r.len};
      end
      mmri_pkg::OP_DECIDE: begin
        if (ov) begin
          if (same) begin
            l_r.len <= merge_len;
          end else if (l_low) begin
            l_r.len <= trim_len;
          end else begin
            r_r.len   <= rnew_len;
            r_r.start <= el_r[63:0];
          end
        end else begin
          l_r.len <= touch_len;
        end
        rest_r.start <= er_r[63:0];
        rest_r.len   <= rest_len;
        rest_r.kind  <= l_r.kind;
      end
      mmri_pkg::OP_EMIT_RD: begin
        ostart_r <= rd_q_r.start;
        olen_r   <= rd_q_r.len;
        okind_r  <= rd_q_r.kind;
      end
      mmri_pkg::OP_EMIT_ZERO: begin
        ostart_r <= '0;
        olen_r   <= '0;
        okind_r  <= '0;
      end
      default: ;
    endcase
  end

  assign out_start  = ostart_r;
  assign out_length = olen_r;
  assign out_kind   = okind_r;

endmodule

### sv/mmri_ctrl.sv
`timescale 1ns / 1ps

module mmri_ctrl #(
  parameter int MAX_REGIONS = 32,
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_entry_index,
  output logic [5:0]        out_entry_count,
  output logic [1:0]        out_status,
  output logic              out_last,
  output mmri_pkg::dp_cmd_t cmd,
  output logic [AW-1:0]     rd_addr,
  output logic [AW-1:0]     wr_addr,
  input  mmri_pkg::dp_sts_t sts
);

  localparam int IW = CW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_CMP, S_ADD_WR, S_ADD_REST,
    S_PAIR_CHK, S_PAIR_RDL, S_PAIR_RDR, S_PAIR_ENDS, S_PAIR_DEC, S_PAIR_WR,
    S_DROP_RD, S_DROP_WR, S_NEXT, S_RESULT, S_RO_RD, S_RO_EMIT
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [IW-1:0]      idx_r;
  logic [IW-1:0]      i_r;
  logic               in_pass_r;
  logic [1:0]         res_r;
  mmri_pkg::verdict_t verdict_r;
  logic               ovalid_r;
  logic [5:0]         oindex_r;
  logic [5:0]         ocount_r;
  logic [1:0]         ostatus_r;
  logic               olast_r;

  logic          out_free;
  logic [IW-1:0] count_w, idx_p1, i_p1;
  logic          full, pass_done, ro_last;

  assign out_free  = !ovalid_r || !out_stall;
  assign count_w   = IW'(count_r);
  assign idx_p1    = idx_r + IW'(1);
  assign i_p1      = i_r + IW'(1);
  assign full      = count_w >= IW'(MAX_REGIONS);
  assign pass_done = idx_p1 >= count_w;
  assign ro_last   = i_p1 == count_w;
  assign in_stall  = state_r != S_IDLE;

  always_comb begin
    cmd.op    = mmri_pkg::OP_NONE;
    cmd.rd_en = 1'b0;
    rd_addr   = i_r[AW-1:0];
    wr_addr   = i_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_kind) cmd.op = mmri_pkg::OP_CARRY_IN;
      end
      S_ADD_RD:   cmd.rd_en = i_r < count_w;
      S_ADD_CMP:  if (sts.lt) cmd.op = mmri_pkg::OP_SWAP;
      S_ADD_WR: begin
        cmd.op  = mmri_pkg::OP_WR_CARRY;
        wr_addr = count_r[AW-1:0];
      end
      S_ADD_REST: cmd.op = mmri_pkg::OP_CARRY_REST;
      S_PAIR_CHK: begin
        cmd.rd_en = !pass_done;
        rd_addr   = idx_r[AW-1:0];
      end
      S_PAIR_RDL: begin
        cmd.op    = mmri_pkg::OP_LOAD_L;
        cmd.rd_en = 1'b1;
        rd_addr   = idx_p1[AW-1:0];
      end
      S_PAIR_RDR:  cmd.op = mmri_pkg::OP_LOAD_R;
      S_PAIR_ENDS: cmd.op = mmri_pkg::OP_ENDS;
      S_PAIR_DEC:  cmd.op = mmri_pkg::OP_DECIDE;
      S_PAIR_WR: begin
        if (verdict_r.wr_l) begin
          cmd.op  = mmri_pkg::OP_WR_L;
          wr_addr = idx_r[AW-1:0];
        end else if (verdict_r.wr_r) begin
          cmd.op  = mmri_pkg::OP_WR_R;
          wr_addr = idx_p1[AW-1:0];
        end
      end
      S_DROP_RD: begin
        cmd.rd_en = i_p1 < count_w;
        rd_addr   = i_p1[AW-1:0];
      end
      S_DROP_WR: cmd.op = mmri_pkg::OP_WR_RD;
      S_RESULT:  if (out_free) cmd.op = mmri_pkg::OP_EMIT_ZERO;
      S_RO_RD:   cmd.rd_en = 1'b1;
      S_RO_EMIT: if (out_free) cmd.op = mmri_pkg::OP_EMIT_RD;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      idx_r     <= '0;
      i_r       <= '0;
      in_pass_r <= 1'b0;
      res_r     <= mmri_pkg::ST_OK;
      verdict_r <= '0;
      ovalid_r  <= 1'b0;
      oindex_r  <= '0;
      ocount_r  <= '0;
      ostatus_r <= mmri_pkg::ST_OK;
      olast_r   <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            i_r       <= '0;
            in_pass_r <= 1'b0;
            res_r     <= mmri_pkg::ST_OK;
            if (!in_kind) begin
              if (full) begin
                res_r   <= mmri_pkg::ST_FULL;
                state_r <= S_RESULT;
              end else begin
                state_r <= S_ADD_RD;
              end
            end else if (count_r == '0) begin
              res_r   <= mmri_pkg::ST_EMPTY;
              state_r <= S_RESULT;
            end else begin
              state_r <= S_RO_RD;
            end
          end
        end
        S_ADD_RD:  state_r <= (i_r < count_w) ? S_ADD_CMP : S_ADD_WR;
        S_ADD_CMP: begin
          i_r     <= i_p1;
          state_r <= S_ADD_RD;
        end
        S_ADD_WR: begin
          count_r <= count_r + CW'(1);
          if (in_pass_r) begin
            state_r <= S_NEXT;
          end else begin
            idx_r   <= '0;
            state_r <= S_PAIR_CHK;
          end
        end
        S_ADD_REST: begin
          in_pass_r <= 1'b1;
          i_r       <= '0;
          if (full) begin
            res_r   <= mmri_pkg::ST_FULL;
            state_r <= S_NEXT;
          end else begin
            state_r <= S_ADD_RD;
          end
        end
        S_PAIR_CHK:  state_r <= pass_done ? S_RESULT : S_PAIR_RDL;
        S_PAIR_RDL:  state_r <= S_PAIR_RDR;
        S_PAIR_RDR:  state_r <= S_PAIR_ENDS;
        S_PAIR_ENDS: state_r <= S_PAIR_DEC;
        S_PAIR_DEC: begin
          verdict_r <= sts.verdict;
          state_r   <= S_PAIR_WR;
        end
        S_PAIR_WR: begin
          if (verdict_r.drop_lo || verdict_r.drop_hi) begin
            i_r     <= verdict_r.drop_lo ? idx_r : idx_p1;
            state_r <= S_DROP_RD;
          end else if (verdict_r.add_rest) begin
            state_r <= S_ADD_REST;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_DROP_RD: begin
          if (i_p1 < count_w) begin
            state_r <= S_DROP_WR;
          end else begin
            count_r <= count_r - CW'(1);
            state_r <= verdict_r.add_rest ? S_ADD_REST : S_NEXT;
          end
        end
        S_DROP_WR: begin
          i_r     <= i_p1;
          state_r <= S_DROP_RD;
        end
        S_NEXT: begin
          idx_r   <= idx_r + IW'(verdict_r.adv);
          state_r <= S_PAIR_CHK;
        end
        S_RESULT: begin
          if (out_free) begin
            ovalid_r  <= 1'b1;
            oindex_r  <= '0;
            ocount_r  <= 6'(count_r);
            ostatus_r <= res_r;
            olast_r   <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        S_RO_RD: state_r <= S_RO_EMIT;
        S_RO_EMIT: begin
          if (out_free) begin
            ovalid_r  <= 1'b1;
            oindex_r  <= 6'(i_r);
            ocount_r  <= 6'(count_r);
            ostatus_r <= mmri_pkg::ST_OK;
            olast_r   <= ro_last;
            i_r       <= i_p1;
            state_r   <= ro_last ? S_IDLE : S_RO_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = ovalid_r;
  assign out_entry_index = oindex_r;
  assign out_entry_count = ocount_r;
  assign out_status      = ostatus_r;
  assign out_last        = olast_r;

endmodule

### sv/memory_map_region_insert_top.sv
`timescale 1ns / 1ps

// Sorted memory map table with merge/trim on insert.
// Input item: in_kind 0 inserts (in_region_start/length/kind), 1 reads the map.
// An insert gives one result item (entry_count, status, last=1). A read gives one
// result item per entry in table order, last set on the final one; an empty
// table gives one item with status 2.
// Insert: the region is placed with one table read and compare per entry, then
// each adjacent pair is checked for merge or trim, and each drop shifts the
// later entries down one by one; the sequencer walks the table memory, which
// has one read and one write address. Read: one table read per entry.
// in_stall is high while an item is being worked; a new item is taken while
// the last result still waits in the output register.
// While out_stall is high a valid result holds and the next result waits.
// Reset clears the entry count and control; table contents need no clearing.
module memory_map_region_insert_top #(
  parameter int MAX_REGIONS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [63:0] in_region_start,
  input  logic [63:0] in_region_length,
  input  logic [7:0]  in_region_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_entry_index,
  output logic [63:0] out_entry_start,
  output logic [63:0] out_entry_length,
  output logic [7:0]  out_entry_kind,
  output logic [5:0]  out_entry_count,
  output logic [1:0]  out_status,
  output logic        out_last
);

  localparam int AW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  mmri_pkg::dp_cmd_t cmd;
  mmri_pkg::dp_sts_t sts;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  mmri_ctrl #(
    .MAX_REGIONS(MAX_REGIONS),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_kind(in_kind),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_entry_index(out_entry_index),
    .out_entry_count(out_entry_count),
    .out_status(out_status),
    .out_last(out_last),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .sts(sts)
  );

  mmri_datapath #(
    .AW(AW)
  ) u_dp (
    .clk(clk),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .in_start(in_region_start),
    .in_length(in_region_length),
    .in_kind(in_region_kind),
    .sts(sts),
    .out_start(out_entry_start),
    .out_length(out_entry_length),
    .out_kind(out_entry_kind)
  );

  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mmri_pkg::ST_EMPTY) |-> out_last && (out_entry_count == 6'd0))
    else $error("empty-read result malformed");

  a_full_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == mmri_pkg::ST_FULL) |-> out_last && (out_entry_index == 6'd0))
    else $error("full-drop result malformed");

  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == mmri_pkg::ST_OK)
    else $error("non-final result with error status");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input taken in the middle of a readout");

endmodule
